>>> rtl/lru_key_value_cache_assert.svh
// Assertion macros shared by the LRU key/value cache RTL.
// Included by the top level; needs no package.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lkv_pkg.sv
// Package for the LRU key/value cache: field widths, operation codes,
// beat structs and the cell control struct. No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int FUNC_W      = 3;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;
	localparam int CNT_W       = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [FUNC_W-1:0] FUNC_GET      = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUT      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} in_t;

	typedef struct packed {
		logic              found;
		logic [VAL_W-1:0]  read_value;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
		logic [CAP_W-1:0]  occupancy;
		logic [CNT_W-1:0]  hits;
		logic [CNT_W-1:0]  misses;
		logic [CNT_W-1:0]  evictions;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} kv_t;

	// How the row of cells moves on a committed request.
	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_FRONT_HIT,
		MODE_FRONT_INS,
		MODE_PULL
	} shift_mode_t;

	typedef struct packed {
		shift_mode_t      mode;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

>>> rtl/lkv_cell.sv
// One recency position of the LRU cache: holds a key/value pair, compares
// its key, and trades data with its neighbors. Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_cell (
	input  logic               clk,
	input  lkv_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               ins_shift,
	input  lkv_pkg::kv_t       left_kv,
	input  lkv_pkg::kv_t       right_kv,
	input  logic               hit_ge_i,
	input  logic               hit_le_i,
	output logic               hit,
	output logic               hit_ge_o,
	output logic               hit_le_o,
	output lkv_pkg::kv_t       kv
);
	import lkv_pkg::*;

	kv_t kv_q;
	kv_t kv_d;

	assign hit      = occupied && (kv_q.key == ctrl.key);
	// hit_ge: a hit sits at this position or further back.
	// hit_le: a hit sits at this position or further forward.
	assign hit_ge_o = hit || hit_ge_i;
	assign hit_le_o = hit || hit_le_i;
	assign kv       = kv_q;

	always_comb begin
		kv_d = kv_q;
		case (ctrl.mode)
			MODE_FRONT_HIT: if (hit_ge_o) begin
				kv_d = left_kv;
			end
			MODE_FRONT_INS: if (ins_shift) begin
				kv_d = left_kv;
			end
			MODE_PULL: if (hit_le_o) begin
				kv_d = right_kv;
			end
			default: kv_d = kv_q;
		endcase
	end

	always_ff @(posedge clk) begin
		kv_q <= kv_d;
	end

endmodule

>>> rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: request and result registers,
// operation decode, statistics and the row of lkv_cell instances.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_assert.svh.
`timescale 1ns / 1ps
//
//  Channel   Signals                         Beat
//  ------    ------------------------------  -----------------------------------
//  in        in_valid / in_ready / in_data    one request: func, key, value
//  out       out_valid / out_ready / out_data one result per request
//  cfg       cfg_wen / cfg_wdata              capacity write, no handshake
//
//  A request is taken into the request register, where the cells compare
//  their keys and, once it commits, shift in one step.
//  A new request is accepted as soon as the previous one has committed, even
//  while its result still waits in the output register; the commit stalls
//  only while that register is full and not being drained.
//  Reset empties the store, zeroes the counters and sets capacity to 16.

module lru_key_value_cache #(
	parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lkv_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lkv_pkg::out_t             out_data
);
	import lkv_pkg::*;

	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic             busy_q;
	in_t              req_s1;
	logic             out_valid_q;
	out_t             out_q;
	logic [CW-1:0]    count_q;
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] evictions_q;
	logic [CAP_W-1:0] capacity_q;

	logic             commit;
	logic             any_hit;
	logic             evict_full;
	logic [CMPW-1:0]  cap_eff;
	logic [VAL_W-1:0] hit_value;
	logic [KEY_W-1:0] last_key;
	shift_mode_t      mode;
	cell_ctrl_t       cell_ctrl;
	kv_t              front_kv;
	out_t             res;
	logic [CW-1:0]    count_next;
	logic [CNT_W-1:0] hits_next;
	logic [CNT_W-1:0] misses_next;
	logic [CNT_W-1:0] evictions_next;

	logic [ENTRIES-1:0] occupied;
	logic [ENTRIES-1:0] ins_shift;
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES:0]   hit_ge;
	logic [ENTRIES:0]   hit_le;
	kv_t                cell_kv [ENTRIES];

	assign in_ready  = !busy_q;
	assign commit    = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Capacity zero acts as one, anything above the row length as the row length.
	always_comb begin
		cap_eff = CMPW'(capacity_q);
		if (capacity_q == '0) begin
			cap_eff = CMPW'(1);
		end else if (cap_eff > CMPW'(ENTRIES)) begin
			cap_eff = CMPW'(ENTRIES);
		end
	end

	assign evict_full = CMPW'(count_q) >= cap_eff;
	assign any_hit    = hit_ge[0];

	always_comb begin
		hit_value = '0;
		last_key  = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			occupied[j] = CW'(j) < count_q;
			// On eviction the last entry is overwritten; otherwise the row grows by one.
			ins_shift[j] = evict_full ? occupied[j] : (CW'(j) <= count_q);
			if (hit_vec[j]) begin
				hit_value = hit_value | cell_kv[j].value;
			end
			if (CW'(j + 1) == count_q) begin
				last_key = last_key | cell_kv[j].key;
			end
		end
	end

	always_comb begin
		res            = '0;
		mode           = MODE_HOLD;
		count_next     = count_q;
		hits_next      = hits_q;
		misses_next    = misses_q;
		evictions_next = evictions_q;
		unique case (req_s1.func)
			FUNC_GET: begin
				res.found = any_hit;
				if (any_hit) begin
					res.read_value = hit_value;
					mode           = MODE_FRONT_HIT;
					hits_next      = (hits_q == '1) ? hits_q : hits_q + 1'b1;
				end else begin
					misses_next = (misses_q == '1) ? misses_q : misses_q + 1'b1;
				end
			end
			FUNC_PUT: begin
				res.found = any_hit;
				if (any_hit) begin
					mode = MODE_FRONT_HIT;
				end else begin
					mode = MODE_FRONT_INS;
					if (evict_full) begin
						res.evicted     = 1'b1;
						res.evicted_key = last_key;
						evictions_next  = (evictions_q == '1) ? evictions_q
							: evictions_q + 1'b1;
					end else begin
						count_next = count_q + 1'b1;
					end
				end
			end
			FUNC_REMOVE: begin
				res.found = any_hit;
				if (any_hit) begin
					mode       = MODE_PULL;
					count_next = count_q - 1'b1;
				end
			end
			FUNC_CONTAINS: begin
				res.found = any_hit;
			end
			FUNC_CLEAR: begin
				count_next     = '0;
				hits_next      = '0;
				misses_next    = '0;
				evictions_next = '0;
			end
			default: begin
			end
		endcase
		res.occupancy = CAP_W'(count_next);
		res.hits      = hits_next;
		res.misses    = misses_next;
		res.evictions = evictions_next;
	end

	// The head cell takes the request key; its value is new on put, kept on get.
	assign front_kv.key   = req_s1.key;
	assign front_kv.value = (req_s1.func == FUNC_PUT) ? req_s1.value : hit_value;

	assign cell_ctrl.mode = commit ? mode : MODE_HOLD;
	assign cell_ctrl.key  = req_s1.key;

	assign hit_ge[ENTRIES] = 1'b0;
	assign hit_le[0]       = 1'b0;

	for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
		kv_t left_kv;
		kv_t right_kv;

		if (j == 0) begin : g_head
			assign left_kv = front_kv;
		end else begin : g_body
			assign left_kv = cell_kv[j-1];
		end

		if (j == ENTRIES - 1) begin : g_tail
			assign right_kv = '0;
		end else begin : g_inner
			assign right_kv = cell_kv[j+1];
		end

		lkv_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.occupied (occupied[j]),
			.ins_shift(ins_shift[j]),
			.left_kv  (left_kv),
			.right_kv (right_kv),
			.hit_ge_i (hit_ge[j+1]),
			.hit_le_i (hit_le[j]),
			.hit      (hit_vec[j]),
			.hit_ge_o (hit_ge[j]),
			.hit_le_o (hit_le[j+1]),
			.kv       (cell_kv[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evictions_q <= '0;
			capacity_q  <= CAP_RESET;
		end else begin
			if (cfg_wen) begin
				capacity_q <= cfg_wdata;
			end
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
				hits_q      <= hits_next;
				misses_q    <= misses_next;
				evictions_q <= evictions_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
		if (commit) begin
			out_q <= res;
		end
	end

`include "lru_key_value_cache_assert.svh"

	// Keys are unique among occupied cells, so at most one cell can match.
	`LKV_ASSERT_NOW(a_single_hit, clk, arst_n, 1'b1, $onehot0(hit_vec), "more than one cell hit")
	`LKV_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(ENTRIES), "occupancy overflow")
	`LKV_ASSERT_NEXT(a_stall_holds, clk, arst_n, busy_q && !commit, busy_q && $stable(req_s1), "stalled request lost")
	`LKV_ASSERT_NEXT(a_commit_result, clk, arst_n, commit, out_valid_q, "committed request gave no result")

endmodule

>>> test/tb.sv
// Self-checking testbench for lru_key_value_cache: a directed table, then random traffic
// checked against an LRU cache predictor in this file, with random stalls on both channels.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module tb;
	import lkv_pkg::*;

	localparam int NSLOT       = DEF_ENTRIES;
	localparam int SLOT_W      = $clog2(NSLOT);
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int POOL_SIZE   = 24;
	localparam int PHASE_ITEMS = 210;

	localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_CLEAR + 1'b1;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = '1;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_wen   = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;

	lru_key_value_cache DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Predicted cache contents. lru_order lists occupied slots first, most recent at 0.
	logic [KEY_W-1:0]  slot_key  [NSLOT];
	logic [VAL_W-1:0]  slot_val  [NSLOT];
	logic              slot_used [NSLOT];
	logic [SLOT_W-1:0] lru_order [NSLOT];
	int                held;
	logic [CNT_W-1:0]  hit_cnt, miss_cnt, evict_cnt;
	logic [CAP_W-1:0]  cap_reg;

	out_t pending_results[$];
	int   err_cnt    = 0;
	int   burst_left = 0;

	typedef struct {
		bit               is_cfg;
		logic [CAP_W-1:0] cap;
		in_t              req;
		bit               typed;
		out_t             want;
	} plan_row_t;

	plan_row_t plan_q[$];

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic int locate_key(logic [KEY_W-1:0] k);
		for (int p = 0; p < held; p++) begin
			if (slot_used[lru_order[p]] && slot_key[lru_order[p]] == k)
				return p;
		end
		return -1;
	endfunction

	function automatic void promote(int p);
		logic [SLOT_W-1:0] s;
		s = lru_order[p];
		for (int i = p; i > 0; i--)
			lru_order[i] = lru_order[i-1];
		lru_order[0] = s;
	endfunction

	// Removes the slot at position p from the occupied region and parks it as the first free one.
	function automatic void unlink(int p);
		logic [SLOT_W-1:0] s;
		s = lru_order[p];
		for (int i = p; i < held - 1; i++)
			lru_order[i] = lru_order[i+1];
		lru_order[held-1] = s;
		slot_used[s] = 1'b0;
		held--;
	endfunction

	function automatic out_t cache_apply(in_t req);
		out_t              r;
		int                pos;
		int                cap;
		logic [SLOT_W-1:0] s;
		r = '0;
		cap = cap_reg;
		if (cap == 0)
			cap = 1;
		if (cap > NSLOT)
			cap = NSLOT;
		if (req.func <= FUNC_CONTAINS) begin
			pos = locate_key(req.key);
			r.found = (pos >= 0);
			case (req.func)
				FUNC_GET: begin
					if (pos >= 0) begin
						r.read_value = slot_val[lru_order[pos]];
						hit_cnt = bump(hit_cnt);
						promote(pos);
					end else begin
						miss_cnt = bump(miss_cnt);
					end
				end
				FUNC_PUT: begin
					if (pos >= 0) begin
						slot_val[lru_order[pos]] = req.value;
						promote(pos);
					end else begin
						if (held >= cap && held > 0) begin
							r.evicted = 1'b1;
							r.evicted_key = slot_key[lru_order[held-1]];
							unlink(held - 1);
							evict_cnt = bump(evict_cnt);
						end
						if (held < NSLOT) begin
							s = lru_order[held];
							slot_key[s] = req.key;
							slot_val[s] = req.value;
							slot_used[s] = 1'b1;
							promote(held);
							held++;
						end
					end
				end
				FUNC_REMOVE: begin
					if (pos >= 0)
						unlink(pos);
				end
				default: ;
			endcase
		end else if (req.func == FUNC_CLEAR) begin
			for (int i = 0; i < NSLOT; i++)
				slot_used[i] = 1'b0;
			held = 0;
			hit_cnt = '0;
			miss_cnt = '0;
			evict_cnt = '0;
		end
		r.occupancy = CAP_W'(held);
		r.hits = hit_cnt;
		r.misses = miss_cnt;
		r.evictions = evict_cnt;
		return r;
	endfunction

	function automatic out_t outcome(bit f, logic [VAL_W-1:0] rd, bit ev, logic [KEY_W-1:0] evk,
			logic [CAP_W-1:0] occ, logic [CNT_W-1:0] h, logic [CNT_W-1:0] m,
			logic [CNT_W-1:0] e);
		return out_t'{f, rd, ev, evk, occ, h, m, e};
	endfunction

	function automatic void add_req(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		plan_row_t row;
		row = '{1'b0, '0, in_t'{f, k, v}, 1'b0, '0};
		plan_q.insert(plan_q.size(), row);
	endfunction

	function automatic void add_checked(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, out_t want);
		plan_row_t row;
		row = '{1'b0, '0, in_t'{f, k, v}, 1'b1, want};
		plan_q.insert(plan_q.size(), row);
	endfunction

	function automatic void add_capacity(logic [CAP_W-1:0] c);
		plan_row_t row;
		row = '{1'b1, c, '0, 1'b0, '0};
		plan_q.insert(plan_q.size(), row);
	endfunction

	task automatic flag_mismatch(string msg);
		err_cnt++;
		if (err_cnt <= 50)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_result(out_t got);
		out_t want;
		if (pending_results.size() == 0) begin
			flag_mismatch("result beat with nothing expected");
			return;
		end
		want = pending_results.pop_front();
		cmp_field("found", got.found, want.found);
		cmp_field("read_value", got.read_value, want.read_value);
		cmp_field("evicted", got.evicted, want.evicted);
		cmp_field("evicted_key", got.evicted_key, want.evicted_key);
		cmp_field("occupancy", got.occupancy, want.occupancy);
		cmp_field("hits", got.hits, want.hits);
		cmp_field("misses", got.misses, want.misses);
		cmp_field("evictions", got.evictions, want.evictions);
	endtask

	// Offers one request beat, opening a new burst after a random gap when the last one ran out.
	task automatic push_beat(in_t req, bit typed, out_t want);
		out_t predicted;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = cache_apply(req);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		burst_left--;
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] c);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		cfg_wen <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cap_reg = c;
	endtask

	initial begin : result_side
		int stall_pct;
		int seg_left;
		int beats;
		stall_pct = 0;
		seg_left = 0;
		beats = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				check_result(out_data);
				beats++;
				// Long hold-off so the result register fills and the request side backs up.
				if (beats == 120 || beats == 1000) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
			end
			if (seg_left == 0) begin
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 30;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
				seg_left = $urandom_range(10, 120);
			end
			seg_left--;
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [KEY_W-1:0]  key_pool [POOL_SIZE];
		logic [CAP_W-1:0]  phase_cap [8];
		int                pool_n;
		int                pick;
		in_t               req;
		for (int i = 0; i < NSLOT; i++) begin
			slot_used[i] = 1'b0;
			lru_order[i] = SLOT_W'(i);
		end
		held = 0;
		hit_cnt = '0;
		miss_cnt = '0;
		evict_cnt = '0;
		cap_reg = CAP_RESET;

		// Empty store after reset, all-zero and all-one keys and values, spare codes.
		add_checked(FUNC_GET, 32'h0, 32'h0, outcome(0, 0, 0, 0, 0, 0, 1, 0));
		add_checked(FUNC_CONTAINS, '1, 32'h0, outcome(0, 0, 0, 0, 0, 0, 1, 0));
		add_checked(FUNC_PUT, 32'h0, '1, outcome(0, 0, 0, 0, 1, 0, 1, 0));
		add_checked(FUNC_PUT, '1, 32'h0, outcome(0, 0, 0, 0, 2, 0, 1, 0));
		add_checked(FUNC_GET, 32'h0, 32'h0, outcome(1, '1, 0, 0, 2, 1, 1, 0));
		add_checked(FUNC_GET, '1, 32'h0, outcome(1, 0, 0, 0, 2, 2, 1, 0));
		add_req(FUNC_PUT, 32'h0, 32'h5A5A_A5A5);
		add_checked(FUNC_CONTAINS, 32'h0, '1, outcome(1, 0, 0, 0, 2, 2, 1, 0));
		add_checked(FUNC_SPARE_FIRST, 32'h0, 32'h0, outcome(0, 0, 0, 0, 2, 2, 1, 0));
		add_checked(FUNC_SPARE_FIRST + 1'b1, 32'h0, '1, outcome(0, 0, 0, 0, 2, 2, 1, 0));
		add_checked(FUNC_SPARE_LAST, '1, '1, outcome(0, 0, 0, 0, 2, 2, 1, 0));
		add_checked(FUNC_REMOVE, '1, 32'h0, outcome(1, 0, 0, 0, 1, 2, 1, 0));
		add_checked(FUNC_REMOVE, '1, 32'h0, outcome(0, 0, 0, 0, 1, 2, 1, 0));
		add_checked(FUNC_GET, '1, 32'h0, outcome(0, 0, 0, 0, 1, 2, 2, 0));
		add_req(FUNC_GET, 32'h0, 32'h0);
		add_checked(FUNC_CLEAR, '1, '1, outcome(0, 0, 0, 0, 0, 0, 0, 0));
		add_checked(FUNC_REMOVE, 32'h5, 32'h0, outcome(0, 0, 0, 0, 0, 0, 0, 0));
		// Capacity of one, then zero, which acts as one.
		add_capacity(5'd1);
		add_checked(FUNC_PUT, 32'h1, 32'h11, outcome(0, 0, 0, 0, 1, 0, 0, 0));
		add_checked(FUNC_PUT, 32'h2, 32'h22, outcome(0, 0, 1, 1, 1, 0, 0, 1));
		add_capacity(5'd0);
		add_checked(FUNC_PUT, 32'h3, 32'h33, outcome(0, 0, 1, 2, 1, 0, 0, 2));
		// Above the slot count, then lowered below the occupancy: the occupancy holds at two.
		add_capacity(5'd31);
		add_checked(FUNC_PUT, 32'h4, 32'h44, outcome(0, 0, 0, 0, 2, 0, 0, 2));
		add_capacity(5'd1);
		add_checked(FUNC_PUT, 32'h5, 32'h55, outcome(0, 0, 1, 3, 2, 0, 0, 3));
		add_checked(FUNC_GET, 32'h3, 32'h0, outcome(0, 0, 0, 0, 2, 0, 1, 3));
		add_req(FUNC_GET, 32'h4, 32'h0);
		add_req(FUNC_PUT, 32'h4, 32'hFFFF_0000);
		add_capacity(5'd16);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].is_cfg)
				set_capacity(plan_q[i].cap);
			else
				push_beat(plan_q[i].req, plan_q[i].typed, plan_q[i].want);
		end

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		phase_cap = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd0, 5'd17, 5'd1, 5'd12};
		phase_cap[7] = CAP_W'($urandom_range(31));

		// Phases run back to back without a clear, so capacity often drops below occupancy.
		for (int ph = 0; ph < 8; ph++) begin
			set_capacity(phase_cap[ph]);
			pool_n = $urandom_range(3, POOL_SIZE);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 34)
					req.func = FUNC_GET;
				else if (pick < 70)
					req.func = FUNC_PUT;
				else if (pick < 80)
					req.func = FUNC_REMOVE;
				else if (pick < 90)
					req.func = FUNC_CONTAINS;
				else if (pick < 92)
					req.func = FUNC_CLEAR;
				else
					req.func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
				if ($urandom_range(99) < 15)
					req.key = $urandom;
				else
					req.key = key_pool[$urandom_range(pool_n - 1)];
				req.value = $urandom;
				push_beat(req, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
